// File: sv/length_prefixed_deframer_top_macros.svh
// Assertion macros for the length-prefixed deframer.
`ifndef LENGTH_PREFIXED_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lpd_pkg.sv
// Types and constants shared by the length-prefixed deframer modules.
package lpd_pkg;

    localparam int LEN_W  = 16;
    localparam int ACC_W  = LEN_W + 1;
    localparam int BYTE_W = 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [ACC_W-1:0]  ACC_SAT       = 17'h10000;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 16'd1023;
    localparam logic [BYTE_W-1:0] CHAR_COLON    = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE     = 8'h39;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DONE    = 2'd2
    } lpd_phase_t;

    typedef enum logic [2:0] {
        ST_DIGIT   = 3'd0,
        ST_HEADER  = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_ERROR   = 3'd3,
        ST_IGNORED = 3'd4,
        ST_CLOSED  = 3'd5
    } lpd_status_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_NON_DIGIT    = 3'd1,
        ERR_TOO_MANY     = 3'd2,
        ERR_EMPTY        = 3'd3,
        ERR_TOO_LARGE    = 3'd4,
        ERR_CLOSED_EARLY = 3'd5
    } lpd_error_t;

    // One input item
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              stream_closed;
    } lpd_item_t;

    // One result item
    typedef struct packed {
        lpd_status_t       status;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic [LEN_W-1:0]  payload_length;
        lpd_error_t        error_code;
    } lpd_result_t;

    // Handoff between the input stage and the parser
    typedef struct packed {
        logic valid;
        logic take;
    } lpd_hs_t;

endpackage

// File: sv/lpd_in_stage.sv
// Input register stage: holds one accepted item until the parser takes it.
module lpd_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lpd_pkg::lpd_item_t s_item,
    input  logic              take,
    output logic              item_valid,
    output lpd_pkg::lpd_item_t item
);
    import lpd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lpd_item_t item_reg;

    // Free slot, or the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: sv/lpd_parse.sv
// Parser: frame state, per-byte step logic and the result register.
module lpd_parse #(
    parameter int MAX_DIGITS = 15,
    parameter int DIGIT_W    = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [lpd_pkg::LEN_W-1:0] cfg_wdata,
    input  lpd_pkg::lpd_hs_t         in_hs,
    input  lpd_pkg::lpd_item_t       item,
    output logic                     take,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lpd_pkg::lpd_result_t     m_result
);
    import lpd_pkg::*;

    lpd_phase_t         phase_reg, phase_next;
    logic [DIGIT_W-1:0] dcount_reg, dcount_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [LEN_W-1:0]   max_len_reg;
    logic               out_valid_reg, out_valid_next;
    lpd_result_t        res_reg, res_next;

    logic [ACC_W+2:0]   acc_sum;
    logic [BYTE_W-1:0]  digit;
    logic [LEN_W-1:0]   remain_dec;
    logic               is_digit;
    logic               mid_frame;
    logic               fire;

    // Item moves into the result register when that register is free or its result is taken
    assign fire    = in_hs.valid && (!out_valid_reg || m_ready);
    assign take    = fire;
    assign m_valid = out_valid_reg;
    assign m_result = res_reg;

    // Decimal accumulate: acc*10 + digit, acc*10 as two shifts
    assign digit    = item.in_byte - CHAR_ZERO;
    assign is_digit = (item.in_byte >= CHAR_ZERO) && (item.in_byte <= CHAR_NINE);
    assign acc_sum  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                    + {{(ACC_W+3-BYTE_W){1'b0}}, digit};
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
    assign mid_frame  = ((phase_reg == PH_PREFIX) && (dcount_reg != '0))
                      || (phase_reg == PH_PAYLOAD);

    // Step logic for one item
    always_comb begin
        phase_next  = phase_reg;
        dcount_next = dcount_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        res_next.status         = ST_IGNORED;
        res_next.data_byte      = '0;
        res_next.last_byte      = 1'b0;
        res_next.payload_length = '0;
        res_next.error_code     = ERR_NONE;

        if (item.stream_closed) begin
            phase_next  = PH_PREFIX;
            dcount_next = '0;
            acc_next    = '0;
            remain_next = '0;
            if (mid_frame) begin
                res_next.status     = ST_ERROR;
                res_next.error_code = ERR_CLOSED_EARLY;
            end else begin
                res_next.status = ST_CLOSED;
            end
        end else begin
            case (phase_reg)
                PH_PREFIX: begin
                    if (item.in_byte == CHAR_COLON) begin
                        if (dcount_reg == '0) begin
                            phase_next          = PH_DONE;
                            res_next.status     = ST_ERROR;
                            res_next.error_code = ERR_EMPTY;
                        end else if (acc_reg > {1'b0, max_len_reg}) begin
                            phase_next          = PH_DONE;
                            res_next.status     = ST_ERROR;
                            res_next.error_code = ERR_TOO_LARGE;
                        end else if (acc_reg == '0) begin
                            phase_next         = PH_DONE;
                            res_next.status    = ST_HEADER;
                            res_next.last_byte = 1'b1;
                        end else begin
                            phase_next              = PH_PAYLOAD;
                            remain_next             = acc_reg[LEN_W-1:0];
                            res_next.status         = ST_HEADER;
                            res_next.payload_length = acc_reg[LEN_W-1:0];
                        end
                    end else if (!is_digit) begin
                        phase_next          = PH_DONE;
                        res_next.status     = ST_ERROR;
                        res_next.error_code = ERR_NON_DIGIT;
                    end else if (dcount_reg >= DIGIT_W'(MAX_DIGITS)) begin
                        phase_next          = PH_DONE;
                        res_next.status     = ST_ERROR;
                        res_next.error_code = ERR_TOO_MANY;
                    end else begin
                        // Saturate so overflow reads as too large
                        if (acc_reg[ACC_W-1] || (acc_sum > {3'b000, ACC_SAT})) begin
                            acc_next = ACC_SAT;
                        end else begin
                            acc_next = acc_sum[ACC_W-1:0];
                        end
                        dcount_next     = dcount_reg + 1'b1;
                        res_next.status = ST_DIGIT;
                    end
                end
                PH_PAYLOAD: begin
                    remain_next        = remain_dec;
                    res_next.status    = ST_PAYLOAD;
                    res_next.data_byte = item.in_byte;
                    if (remain_dec == '0) begin
                        phase_next         = PH_DONE;
                        res_next.last_byte = 1'b1;
                    end
                end
                default: begin
                    res_next.status = ST_IGNORED;
                end
            endcase
        end
    end

    // Result valid flag
    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Frame state and config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_PREFIX;
            dcount_reg    <= '0;
            acc_reg       <= '0;
            remain_reg    <= '0;
            max_len_reg   <= MAX_LEN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (fire) begin
                phase_reg  <= phase_next;
                dcount_reg <= dcount_next;
                acc_reg    <= acc_next;
                remain_reg <= remain_next;
            end
        end
    end

    // Result payload register
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

// File: sv/length_prefixed_deframer_top.sv
// Top level of the decimal length-prefixed deframer.
//
//   channel   direction  tdata (low bit up)                         tuser / tlast
//   s_        in         in_byte[7:0]                               stream_closed / -
//   m_        out        data_byte[7:0], payload_length[23:8],      status[2:0] /
//                        error_code[26:24], zero[31:27]             last_byte
//   cfg_      in         max_payload_len on cfg_wdata, cfg_we      -
//
// One byte per cycle sustained while m_tready stays high; a result is registered after
// its input transfer (input register, then step logic into the result register).
// Synchronous active-low reset: prefix phase, counters zero, max_payload_len 1023.
// With m_tready low the result holds; one more item waits in the input register,
// then s_tready drops.
`include "length_prefixed_deframer_top_macros.svh"

module length_prefixed_deframer_top #(
    parameter int MAX_DIGITS = 15
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config
    input  logic                            cfg_we,
    input  logic [lpd_pkg::LEN_W-1:0]       cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpd_pkg::BYTE_W-1:0]      s_tdata,   // in_byte
    input  logic                            s_tuser,   // stream_closed
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpd_pkg::OUT_TDATA_W-1:0] m_tdata,   // data_byte, payload_length, error_code
    output logic [2:0]                      m_tuser,   // status
    output logic                            m_tlast    // last_byte
);
    import lpd_pkg::*;

    localparam int DIGIT_W = $clog2(MAX_DIGITS + 1);

    lpd_item_t   s_item;
    lpd_item_t   item;
    lpd_hs_t     in_hs;
    logic        item_valid;
    logic        take;
    lpd_result_t result;

    assign s_item.in_byte       = s_tdata;
    assign s_item.stream_closed = s_tuser;
    assign in_hs.valid          = item_valid;
    assign in_hs.take           = take;

    lpd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (in_hs.take),
        .item_valid (item_valid),
        .item       (item)
    );

    lpd_parse #(
        .MAX_DIGITS (MAX_DIGITS),
        .DIGIT_W    (DIGIT_W)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_hs     (in_hs),
        .item      (item),
        .take      (take),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (result)
    );

    // Pack result fields
    assign m_tuser = result.status;
    assign m_tlast = result.last_byte;
    assign m_tdata = {{(OUT_TDATA_W - BYTE_W - LEN_W - 3){1'b0}},
                      result.error_code, result.payload_length, result.data_byte};

    // Checks
    `LPD_ASSERT_NOW(a_data_only_payload, aclk, aresetn, m_tvalid && (m_tuser != ST_PAYLOAD), m_tdata[7:0] == 8'd0, "data byte set outside payload")
    `LPD_ASSERT_NOW(a_err_only_error, aclk, aresetn, m_tvalid && (m_tuser != ST_ERROR), m_tdata[26:24] == 3'd0, "error code set without error status")
    `LPD_ASSERT_NOW(a_last_kind, aclk, aresetn, m_tvalid && m_tlast, (m_tuser == ST_PAYLOAD) || (m_tuser == ST_HEADER), "last marked on wrong status")
    `LPD_ASSERT_NOW(a_header_len, aclk, aresetn, m_tvalid && (m_tuser == ST_HEADER) && !m_tlast, m_tdata[23:8] != 16'd0, "open header with zero length")
    `LPD_ASSERT_NEXT(a_stall_slot, aclk, aresetn, item_valid && m_tvalid && !m_tready, item_valid, "held input item lost during stall")

endmodule
